// ===== src/circular_disk_seek_scheduler_defines.svh =====
// Assertion macros shared by the seek scheduler RTL.
`ifndef CIRCULAR_DISK_SEEK_SCHEDULER_DEFINES_SVH
`define CIRCULAR_DISK_SEEK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define CDSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdss: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define CDSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdss: next-cycle check failed");

`endif

// ===== src/cdss_pkg.sv =====
// Types and constants of the circular disk seek scheduler.
`default_nettype none

package cdss_pkg;

  localparam int CYL_W  = 16;
  localparam int MOVE_W = 18;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_START_HEAD = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_CYL    = 2'd2;

  localparam logic POLICY_CSCAN = 1'b0;
  localparam logic POLICY_CLOOK = 1'b1;

  localparam logic [CYL_W-1:0] MAX_CYL_RESET = 16'd499;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last_request;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]  served_cylinder;
    logic [MOVE_W-1:0] movement_so_far;
    logic [MOVE_W-1:0] job_total;
    logic              last_served;
  } out_item_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROT,
    S_CALC,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CYL_W-1:0] cyl;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/cdss_cell.sv =====
// One cell of the sorted request chain: insert, rotate and shift-out.
`default_nettype none

module cdss_cell (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire cdss_pkg::cell_ctrl_t      ctrl,
  input  wire                            tail_sel,
  input  wire                            prev_take,
  input  wire [cdss_pkg::CYL_W-1:0]      prev_val,
  input  wire                            prev_valid,
  input  wire [cdss_pkg::CYL_W-1:0]      next_val,
  input  wire                            next_valid,
  output logic [cdss_pkg::CYL_W-1:0]     val,
  output logic                           valid,
  output logic                           take
);

  logic [cdss_pkg::CYL_W-1:0] val_r, val_nxt;
  logic                       valid_r, valid_nxt;

  // This cell is at or beyond the insertion point.
  assign take  = !valid_r || (val_r > ctrl.cyl);
  assign val   = val_r;
  assign valid = valid_r;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      cdss_pkg::OP_INSERT: begin
        if (prev_take) begin
          val_nxt   = prev_val;
          valid_nxt = prev_valid;
        end else if (take) begin
          val_nxt   = ctrl.cyl;
          valid_nxt = 1'b1;
        end
      end
      cdss_pkg::OP_ROTATE: begin
        val_nxt = tail_sel ? ctrl.cyl : next_val;
      end
      cdss_pkg::OP_SHIFT: begin
        val_nxt   = next_val;
        valid_nxt = next_valid;
      end
      default: begin
        val_nxt   = val_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/circular_disk_seek_scheduler.sv =====
// Top level of the C-SCAN / C-LOOK disk seek scheduler.
// Requests arrive on in_valid/in_ready, one transfer per cycle while loading, and are
// insertion-sorted into a chain of MAX_REQUESTS cells. A cylinder above
// max_cylinder is stored as max_cylinder; a request past capacity is dropped.
// The transfer that carries last_request closes the job: the chain then
// rotates the requests at or below the start head to its tail, works out
// the job totals, and shifts out one result per cycle on out_valid/out_ready
// in service order, unless the receiver stalls. in_ready is high only while loading.
// Results sit in one output register; while the receiver stalls the
// chain holds, and the last result may wait there while the next job loads.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata with no wait.
// Synchronous reset clears the chain, the job state and the output valid,
// and loads policy C-SCAN, start head 0 and top cylinder 499.
`default_nettype none

module circular_disk_seek_scheduler #(
  parameter int MAX_REQUESTS = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire cdss_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output cdss_pkg::out_item_t              out_data,
  input  wire                              cfg_we,
  input  wire [cdss_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire [cdss_pkg::CFG_DW-1:0]       cfg_wdata
);

`include "circular_disk_seek_scheduler_defines.svh"

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int MW = cdss_pkg::MOVE_W;
  localparam int YW = cdss_pkg::CYL_W;

  // configuration
  logic          policy_r;
  logic [YW-1:0] start_head_r;
  logic [YW-1:0] max_cyl_r;

  // job control
  cdss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] rot_cnt_r;
  logic [CW-1:0] emit_cnt_r;
  logic [CW-1:0] nup_r;
  logic [YW-1:0] max_all_r;
  logic [YW-1:0] min_r;
  logic [YW-1:0] max_low_r;
  logic [MW-1:0] low_base_r;
  logic [YW-1:0] sub_r;
  logic [MW-1:0] total_r;

  logic                out_valid_r;
  cdss_pkg::out_item_t out_data_r;

  // chain
  cdss_pkg::cell_ctrl_t ctrl;
  logic [YW-1:0] cell_val   [MAX_REQUESTS];
  logic          cell_valid [MAX_REQUESTS];
  logic          cell_take  [MAX_REQUESTS];

  logic          in_fire;
  logic          full;
  logic [YW-1:0] cyl_clamped;
  logic [YW-1:0] head_eff;
  logic [YW-1:0] head_val;
  logic          rot_go;
  logic          out_load;
  logic          emit_last;

  assign in_ready    = (state_r == cdss_pkg::S_LOAD);
  assign in_fire     = in_valid && in_ready;
  assign full        = (count_r == CW'(MAX_REQUESTS));
  assign cyl_clamped = (in_data.cylinder > max_cyl_r) ? max_cyl_r : in_data.cylinder;
  assign head_eff    = (start_head_r > max_cyl_r) ? max_cyl_r : start_head_r;
  assign head_val    = cell_val[0];
  // lower-group requests form the sorted prefix; move them to the tail
  assign rot_go      = (rot_cnt_r != count_r) && (head_val <= head_eff);
  assign out_load    = !out_valid_r || out_ready;
  assign emit_last   = (emit_cnt_r == (count_r - CW'(1)));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
      logic          p_take, p_valid, n_valid;
      logic [YW-1:0] p_val, n_val;
      if (gi == 0) begin : g_first
        assign p_take  = 1'b0;
        assign p_val   = '0;
        assign p_valid = 1'b0;
      end else begin : g_mid
        assign p_take  = cell_take[gi-1];
        assign p_val   = cell_val[gi-1];
        assign p_valid = cell_valid[gi-1];
      end
      if (gi == MAX_REQUESTS - 1) begin : g_last
        assign n_val   = '0;
        assign n_valid = 1'b0;
      end else begin : g_inner
        assign n_val   = cell_val[gi+1];
        assign n_valid = cell_valid[gi+1];
      end
      cdss_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .tail_sel   (count_r == CW'(gi + 1)),
        .prev_take  (p_take),
        .prev_val   (p_val),
        .prev_valid (p_valid),
        .next_val   (n_val),
        .next_valid (n_valid),
        .val        (cell_val[gi]),
        .valid      (cell_valid[gi]),
        .take       (cell_take[gi])
      );
    end
  endgenerate

  // next state and chain command
  always_comb begin
    state_nxt = state_r;
    ctrl.op   = cdss_pkg::OP_HOLD;
    ctrl.cyl  = cyl_clamped;
    unique case (state_r)
      cdss_pkg::S_LOAD: begin
        if (in_fire) begin
          if (!full) begin
            ctrl.op = cdss_pkg::OP_INSERT;
          end
          if (in_data.last_request) begin
            state_nxt = cdss_pkg::S_ROT;
          end
        end
      end
      cdss_pkg::S_ROT: begin
        ctrl.cyl = head_val;
        if (rot_go) begin
          ctrl.op = cdss_pkg::OP_ROTATE;
        end else begin
          state_nxt = cdss_pkg::S_CALC;
        end
      end
      cdss_pkg::S_CALC: begin
        state_nxt = cdss_pkg::S_EMIT;
      end
      cdss_pkg::S_EMIT: begin
        if (out_load) begin
          ctrl.op = cdss_pkg::OP_SHIFT;
          if (emit_last) begin
            state_nxt = cdss_pkg::S_LOAD;
          end
        end
      end
      default: state_nxt = cdss_pkg::S_LOAD;
    endcase
  end

  // job totals, worked out once the split is known
  logic [CW-1:0] n_up;
  logic          has_up, has_low;
  logic [MW-1:0] up_run, low_base_c, total_c;
  logic [YW-1:0] head_u, sub_c;

  always_comb begin
    n_up    = count_r - rot_cnt_r;
    has_up  = (n_up != '0);
    has_low = (rot_cnt_r != '0);
    up_run  = has_up ? (MW'(max_all_r) - MW'(head_eff)) : '0;
    head_u  = has_up ? max_all_r : head_eff;
    if (policy_r == cdss_pkg::POLICY_CSCAN) begin
      // sweep to the top, then back to zero
      low_base_c = (MW'(max_cyl_r) << 1) - MW'(head_eff);
      sub_c      = '0;
    end else begin
      // jump straight to the lowest request
      low_base_c = up_run + MW'(head_u) - MW'(min_r);
      sub_c      = min_r;
    end
    if (has_low) begin
      total_c = low_base_c + MW'(max_low_r) - MW'(sub_c);
    end else if (policy_r == cdss_pkg::POLICY_CLOOK) begin
      total_c = up_run;
    end else begin
      total_c = low_base_c;
    end
  end

  // movement on reaching the cylinder at the chain head
  logic [MW-1:0] move_c;
  assign move_c = (emit_cnt_r < nup_r) ? (MW'(head_val) - MW'(head_eff))
                                       : (low_base_r + MW'(head_val) - MW'(sub_r));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= cdss_pkg::POLICY_CSCAN;
      start_head_r <= '0;
      max_cyl_r    <= cdss_pkg::MAX_CYL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cdss_pkg::REG_POLICY:     policy_r     <= cfg_wdata[0];
        cdss_pkg::REG_START_HEAD: start_head_r <= cfg_wdata;
        cdss_pkg::REG_MAX_CYL:    max_cyl_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdss_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rot_cnt_r  <= '0;
      emit_cnt_r <= '0;
      max_all_r  <= '0;
    end else begin
      if (ctrl.op == cdss_pkg::OP_INSERT) begin
        count_r <= count_r + CW'(1);
        if (cyl_clamped > max_all_r) begin
          max_all_r <= cyl_clamped;
        end
      end
      if (in_fire && in_data.last_request) begin
        rot_cnt_r <= '0;
      end
      if (state_r == cdss_pkg::S_ROT && rot_go) begin
        rot_cnt_r <= rot_cnt_r + CW'(1);
      end
      if (state_r == cdss_pkg::S_CALC) begin
        emit_cnt_r <= '0;
      end
      if (state_r == cdss_pkg::S_EMIT && out_load) begin
        emit_cnt_r <= emit_cnt_r + CW'(1);
        if (emit_last) begin
          count_r   <= '0;
          max_all_r <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == cdss_pkg::S_ROT) begin
      if (rot_cnt_r == '0) begin
        min_r <= head_val;
      end
      if (rot_go) begin
        max_low_r <= head_val;
      end
    end
    if (state_r == cdss_pkg::S_CALC) begin
      low_base_r <= low_base_c;
      sub_r      <= sub_c;
      total_r    <= total_c;
      nup_r      <= n_up;
    end
    if (state_r == cdss_pkg::S_EMIT && out_load) begin
      out_data_r.served_cylinder <= head_val;
      out_data_r.movement_so_far <= move_c;
      out_data_r.job_total       <= total_r;
      out_data_r.last_served     <= emit_last;
    end
  end

  // output register: loads from the chain, frees on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cdss_pkg::S_EMIT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  `CDSS_ASSERT_IMP(a_rot_bound, state_r == cdss_pkg::S_ROT, rot_cnt_r <= count_r)
  `CDSS_ASSERT_IMP(a_emit_nonempty, state_r == cdss_pkg::S_EMIT, count_r != '0)
  `CDSS_ASSERT_IMP(a_move_le_total, out_valid_r,
    out_data_r.movement_so_far <= out_data_r.job_total)
  `CDSS_ASSERT_NEXT(a_last_starts_rot, in_fire && in_data.last_request,
    state_r == cdss_pkg::S_ROT)

endmodule

`default_nettype wire

// ===== tb/tb_circular_disk_seek_scheduler.sv =====
// Self-checking testbench for the C-SCAN / C-LOOK disk seek scheduler.
`default_nettype none

module tb_circular_disk_seek_scheduler;

  timeunit 1ns;
  timeprecision 1ps;

  // Sizing and pacing.
  localparam int MAX_REQ        = 64;
  localparam int ITEM_TARGET    = 410;
  localparam int SETTLE_CYCLES  = MAX_REQ + 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int IDLE_PCT       = 6;

  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [cdss_pkg::CFG_AW-1:0] REG_UNUSED = 2'd3;

  // Directed table: a row is either a register write or one request transfer.
  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [cdss_pkg::CFG_AW-1:0] addr;
    logic [cdss_pkg::CFG_DW-1:0] data;
    cdss_pkg::in_item_t          req;
    logic                        typed;  // single-result job with its result written out
    cdss_pkg::out_item_t         res;
  } row_t;

  // Rows with typed results are one-request jobs whose movement can be worked
  // out by hand; the rest go through the service-order predictor.
  localparam row_t DIRECTED [30] = '{
    // Reset setup: C-SCAN, head 0, top cylinder 499.
    '{ROW_REQ, '0, '0, '{16'd100,   1'b1}, 1'b1, '{16'd100, 18'd100, 18'd998, 1'b1}},
    // Cylinder above the top is clamped.
    '{ROW_REQ, '0, '0, '{16'd65535, 1'b1}, 1'b1, '{16'd499, 18'd499, 18'd998, 1'b1}},
    // Request at the head itself belongs to the lower group.
    '{ROW_REQ, '0, '0, '{16'd0,     1'b1}, 1'b1, '{16'd0,   18'd998, 18'd998, 1'b1}},
    '{ROW_REQ, '0, '0, '{16'd300,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd50,    1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd499,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd0,     1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd200,   1'b1}, 1'b0, '0},
    // C-LOOK from the middle of the disk.
    '{ROW_CFG, cdss_pkg::REG_POLICY,     16'(cdss_pkg::POLICY_CLOOK), '0, 1'b0, '0},
    '{ROW_CFG, cdss_pkg::REG_START_HEAD, 16'd250,                     '0, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd400,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd100,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd250,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd260,   1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd10,    1'b1}, 1'b0, '0},
    // Only a lower request: jump straight down to it.
    '{ROW_REQ, '0, '0, '{16'd100,   1'b1}, 1'b1, '{16'd100, 18'd150, 18'd150, 1'b1}},
    // No lower requests: C-LOOK adds no jump.
    '{ROW_REQ, '0, '0, '{16'd300,   1'b1}, 1'b1, '{16'd300, 18'd50,  18'd50,  1'b1}},
    // Head above the top cylinder is pulled down to it.
    '{ROW_CFG, cdss_pkg::REG_MAX_CYL,    16'd100,                     '0, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd65535, 1'b1}, 1'b1, '{16'd100, 18'd0,   18'd0,   1'b1}},
    '{ROW_CFG, REG_UNUSED,               16'hFFFF,                    '0, 1'b0, '0},
    // Full-width extremes under C-SCAN.
    '{ROW_CFG, cdss_pkg::REG_POLICY,     16'(cdss_pkg::POLICY_CSCAN), '0, 1'b0, '0},
    '{ROW_CFG, cdss_pkg::REG_START_HEAD, 16'hFFFF,                    '0, 1'b0, '0},
    '{ROW_CFG, cdss_pkg::REG_MAX_CYL,    16'hFFFF,                    '0, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd65535, 1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd0,     1'b1}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd0,     1'b1}, 1'b1, '{16'd0, 18'd65535, 18'd65535, 1'b1}},
    '{ROW_CFG, cdss_pkg::REG_START_HEAD, 16'd0,                       '0, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd65535, 1'b1}, 1'b1,
      '{16'd65535, 18'd65535, 18'd131070, 1'b1}},
    // Duplicate cylinders.
    '{ROW_REQ, '0, '0, '{16'd1,     1'b0}, 1'b0, '0},
    '{ROW_REQ, '0, '0, '{16'd1,     1'b1}, 1'b0, '0}
  };

  // DUT-facing signals; those the bench drives are known from time zero.
  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  cdss_pkg::in_item_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  cdss_pkg::out_item_t         out_data;
  logic                        cfg_we    = 1'b0;
  logic [cdss_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [cdss_pkg::CFG_DW-1:0] cfg_wdata = '0;

  // Shadow of the configuration registers, updated on every write.
  logic                        sweep_policy;
  logic [cdss_pkg::CYL_W-1:0]  start_cyl;
  logic [cdss_pkg::CYL_W-1:0]  top_cyl;

  // Requests of the open job in ascending order, and results still owed.
  logic [cdss_pkg::CYL_W-1:0]  queued_cyls[$];
  cdss_pkg::out_item_t         due_services[$];

  int                accepted_reqs = 0;
  int                mismatches    = 0;

  // Stimulus shaping: quiet turns random idling off on both sides, and the
  // hold request makes the receiver back off for one long stretch.
  bit                quiet         = 1'b0;
  bit                rx_hold_req   = 1'b0;
  bit                rx_hold_taken = 1'b0;

  circular_disk_seek_scheduler #(
    .MAX_REQUESTS(MAX_REQ)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the DUT hangs or owes results forever.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Service-order predictor. Called once per accepted request transfer:
  // inserts the clamped cylinder (unless the job is already full) and, on
  // the closing request, queues the whole service order with movements.
  // ---------------------------------------------------------------------
  function automatic void schedule_request(input cdss_pkg::in_item_t req);
    logic [cdss_pkg::CYL_W-1:0]  cyl;
    logic [cdss_pkg::CYL_W-1:0]  head;
    logic [cdss_pkg::MOVE_W-1:0] moved;
    logic [cdss_pkg::CYL_W-1:0]  order[$];
    logic [cdss_pkg::MOVE_W-1:0] marks[$];
    cdss_pkg::out_item_t         res;
    int                          split;
    int                          pos;
    cyl = (req.cylinder > top_cyl) ? top_cyl : req.cylinder;
    // Past capacity the request is dropped; a closing flag still counts.
    if (queued_cyls.size() < MAX_REQ) begin
      pos = 0;
      while (pos < queued_cyls.size() && queued_cyls[pos] <= cyl) pos++;
      queued_cyls.insert(pos, cyl);
    end
    if (!req.last_request) return;

    head  = (start_cyl > top_cyl) ? top_cyl : start_cyl;
    moved = '0;
    split = 0;
    while (split < queued_cyls.size() && queued_cyls[split] <= head) split++;

    // Upper group, climbing from the head.
    for (pos = split; pos < queued_cyls.size(); pos++) begin
      moved += queued_cyls[pos] - head;
      head   = queued_cyls[pos];
      order.push_back(head);
      marks.push_back(moved);
    end
    // C-SCAN sweeps to the top and returns to zero no matter what is left;
    // C-LOOK jumps to the lowest request only if there is a lower group.
    if (sweep_policy == cdss_pkg::POLICY_CSCAN) begin
      moved += top_cyl - head;
      moved += top_cyl;
      head   = '0;
    end else if (split != 0) begin
      moved += head - queued_cyls[0];
      head   = queued_cyls[0];
    end
    // Lower group, bottom up.
    for (pos = 0; pos < split; pos++) begin
      moved += queued_cyls[pos] - head;
      head   = queued_cyls[pos];
      order.push_back(head);
      marks.push_back(moved);
    end

    for (pos = 0; pos < order.size(); pos++) begin
      res.served_cylinder = order[pos];
      res.movement_so_far = marks[pos];
      res.job_total       = moved;
      res.last_served     = (pos == order.size() - 1);
      due_services.push_back(res);
    end
    queued_cyls.delete();
  endfunction

  // Random cylinder, biased toward the ends of the disk and the head.
  function automatic logic [cdss_pkg::CYL_W-1:0] pick_cylinder();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 18) return top_cyl;
    if (roll < 26) return '1;
    if (roll < 40) begin
      return start_cyl + cdss_pkg::CYL_W'($urandom_range(0, 6)) - cdss_pkg::CYL_W'(3);
    end
    if (roll < 70) return cdss_pkg::CYL_W'($urandom_range(0, top_cyl));
    return cdss_pkg::CYL_W'($urandom);
  endfunction

  // Mostly short jobs, now and then a long one that can overflow the chain.
  function automatic int pick_job_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) return $urandom_range(1, 8);
    if (roll < 97) return $urandom_range(9, 30);
    return $urandom_range(50, MAX_REQ + 6);
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. Every task below is entered and left just after a falling
  // edge, so each input sees at most one assignment per time step.
  // ---------------------------------------------------------------------

  // One config write; the shadow registers follow the masking of the block.
  task automatic cfg_write(input logic [cdss_pkg::CFG_AW-1:0] addr,
                           input logic [cdss_pkg::CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      cdss_pkg::REG_POLICY:     sweep_policy = data[0];
      cdss_pkg::REG_START_HEAD: start_cyl    = data;
      cdss_pkg::REG_MAX_CYL:    top_cyl      = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One request transfer, with random idle cycles ahead of it. A typed
  // result replaces the prediction of a one-request job.
  task automatic send_request(input cdss_pkg::in_item_t req, input logic typed,
                              input cdss_pkg::out_item_t res);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    accepted_reqs++;
    schedule_request(req);
    if (typed) begin
      void'(due_services.pop_back());
      due_services.push_back(res);
    end
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the chain go quiet.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (due_services.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_job(input int n);
    cdss_pkg::in_item_t req;
    for (int k = 0; k < n; k++) begin
      req.cylinder     = pick_cylinder();
      req.last_request = (k == n - 1);
      send_request(req, 1'b0, '0);
    end
  endtask

  // New disk geometry and policy; extremes come up often.
  task automatic pick_geometry();
    logic [cdss_pkg::CFG_DW-1:0] top;
    logic [cdss_pkg::CFG_DW-1:0] head;
    int                          roll;
    roll = $urandom_range(0, 99);
    if (roll < 15)      top = 16'd1;
    else if (roll < 30) top = 16'hFFFF;
    else if (roll < 60) top = cdss_pkg::CFG_DW'($urandom_range(1, 600));
    else                top = cdss_pkg::CFG_DW'($urandom_range(1, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 25)      head = '0;
    else if (roll < 40) head = 16'hFFFF;
    else if (roll < 55) head = top;
    else                head = cdss_pkg::CFG_DW'($urandom_range(0, top));
    cfg_write(cdss_pkg::REG_MAX_CYL, top);
    cfg_write(cdss_pkg::REG_START_HEAD, head);
    // Upper bits of the policy word are junk; only bit 0 counts.
    cfg_write(cdss_pkg::REG_POLICY, cdss_pkg::CFG_DW'($urandom));
    if ($urandom_range(0, 9) == 0) cfg_write(REG_UNUSED, cdss_pkg::CFG_DW'($urandom));
  endtask

  // A phase: fresh setup, a few jobs back to back, then a full drain.
  task automatic run_phase();
    pick_geometry();
    repeat ($urandom_range(2, 5)) run_job(pick_job_size());
    drain_and_settle();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin : rx_driver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_taken = 1'b1;
        hold_left     = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each result transfer against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    cdss_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_services.size() == 0) begin
        $error("result with nothing owed: served_cylinder %0d", out_data.served_cylinder);
        mismatches++;
      end else begin
        want = due_services.pop_front();
        if (out_data.served_cylinder !== want.served_cylinder) begin
          $error("served_cylinder: expected %0d, got %0d",
                 want.served_cylinder, out_data.served_cylinder);
          mismatches++;
        end
        if (out_data.movement_so_far !== want.movement_so_far) begin
          $error("movement_so_far: expected %0d, got %0d",
                 want.movement_so_far, out_data.movement_so_far);
          mismatches++;
        end
        if (out_data.job_total !== want.job_total) begin
          $error("job_total: expected %0d, got %0d", want.job_total, out_data.job_total);
          mismatches++;
        end
        if (out_data.last_served !== want.last_served) begin
          $error("last_served: expected %0d, got %0d", want.last_served, out_data.last_served);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    // Shadow registers start at the reset values of the block.
    sweep_policy = cdss_pkg::POLICY_CSCAN;
    start_cyl    = '0;
    top_cyl      = cdss_pkg::MAX_CYL_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Register rows only land on an idle block.
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        drain_and_settle();
        cfg_write(DIRECTED[r].addr, DIRECTED[r].data);
      end else begin
        send_request(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end
    drain_and_settle();

    // Overflow: more requests than the chain holds, closing flag on a dropped one.
    pick_geometry();
    run_job(MAX_REQ + 3);
    drain_and_settle();

    // Receiver backs off for a long stretch while jobs keep coming, so the
    // output register fills, the chain holds and in_ready drops.
    pick_geometry();
    rx_hold_req = 1'b1;
    repeat (4) run_job($urandom_range(4, 10));
    drain_and_settle();

    // A stretch with no idle cycles on either side.
    quiet = 1'b1;
    repeat (2) run_phase();
    quiet = 1'b0;

    while (accepted_reqs < ITEM_TARGET) run_phase();

    // drain_and_settle already waited out every owed result; any stray
    // result during the settle window was flagged by the checker.
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
